/* hdl/cpot_pkg.sv */
// Shared widths and types of the closest-point-on-triangle pipeline.
`default_nettype none
package cpot_pkg;

	localparam int CRD_W  = 32;
	localparam int DIF_W  = CRD_W + 1;
	localparam int DP_W   = 2 * DIF_W;
	localparam int DOT_W  = DP_W + 1;
	localparam int EDG_W  = DOT_W + 1;
	localparam int TT_W   = EDG_W + 1;
	localparam int VP_W   = 2 * DOT_W;
	localparam int VV_W   = VP_W + 1;
	localparam int NP_W   = TT_W + DIF_W;
	localparam int FP_W   = DIF_W + VV_W;
	localparam int DEN_W  = VV_W + 3;
	localparam int NUM_W  = FP_W + 2;
	localparam int QB     = CRD_W + 2;
	localparam int DIV_LAT    = QB + 2;
	localparam int PIPE_DEPTH = 19 + DIV_LAT;

	typedef struct packed {
		logic ovf;
		logic negq;
	} div_flags_t;

	typedef struct packed {
		logic ca;
		logic cb;
		logic pab;
		logic cc;
		logic pac;
		logic e56ge;
	} rgn_flags_t;

endpackage
`default_nettype wire

/* hdl/closest_point_on_triangle_unit.sv */
// Closest point on a 2D triangle: top level pipeline.
//
// Input channel in_valid/in_ready carries one request: query point and the
// three corners A, B, C, all signed Q16.16. Output channel out_valid/out_ready
// returns the nearest triangle point and a degenerate flag (zero divisor,
// result is corner A). Every request gives exactly one result, in order.
// Throughput is one request per cycle while the output is not stalled. The
// depth is set by the four-stage multipliers (three levels of products) and
// the 36-stage divider (two operand setup stages, then one quotient bit per
// stage for 34 bits).
// Results beyond the signed 32-bit range saturate.
// The whole pipe advances together: when out_valid is high and out_ready is
// low, every stage holds and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
module closest_point_on_triangle_unit
	import cpot_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] corner_a_x,
	input  wire logic signed [31:0] corner_a_y,
	input  wire logic signed [31:0] corner_b_x,
	input  wire logic signed [31:0] corner_b_y,
	input  wire logic signed [31:0] corner_c_x,
	input  wire logic signed [31:0] corner_c_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      closest_x,
	output logic signed [31:0]      closest_y,
	output logic                    degenerate
);

	localparam int SUM_W = QB + 3;
	localparam logic signed [31:0] CRD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CRD_MIN = 32'sh8000_0000;

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en       = !vld_q[PIPE_DEPTH-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// stage 1: differences
	logic signed [CRD_W-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [DIF_W-1:0] abx_s1, aby_s1, acx_s1, acy_s1, cbx_s1, cby_s1;
	logic signed [DIF_W-1:0] apx_s1, apy_s1, bpx_s1, bpy_s1, cpx_s1, cpy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= corner_a_x;
			ay_s1  <= corner_a_y;
			bx_s1  <= corner_b_x;
			by_s1  <= corner_b_y;
			cx_s1  <= corner_c_x;
			cy_s1  <= corner_c_y;
			abx_s1 <= DIF_W'(corner_b_x) - DIF_W'(corner_a_x);
			aby_s1 <= DIF_W'(corner_b_y) - DIF_W'(corner_a_y);
			acx_s1 <= DIF_W'(corner_c_x) - DIF_W'(corner_a_x);
			acy_s1 <= DIF_W'(corner_c_y) - DIF_W'(corner_a_y);
			cbx_s1 <= DIF_W'(corner_c_x) - DIF_W'(corner_b_x);
			cby_s1 <= DIF_W'(corner_c_y) - DIF_W'(corner_b_y);
			apx_s1 <= DIF_W'(point_x) - DIF_W'(corner_a_x);
			apy_s1 <= DIF_W'(point_y) - DIF_W'(corner_a_y);
			bpx_s1 <= DIF_W'(point_x) - DIF_W'(corner_b_x);
			bpy_s1 <= DIF_W'(point_y) - DIF_W'(corner_b_y);
			cpx_s1 <= DIF_W'(point_x) - DIF_W'(corner_c_x);
			cpy_s1 <= DIF_W'(point_y) - DIF_W'(corner_c_y);
		end
	end

	// dot product terms, out at stage 5
	logic signed [DIF_W-1:0] dpa [12];
	logic signed [DIF_W-1:0] dpb [12];
	logic signed [DP_W-1:0]  dpp [12];

	always_comb begin
		dpa[0]  = abx_s1; dpb[0]  = apx_s1;
		dpa[1]  = aby_s1; dpb[1]  = apy_s1;
		dpa[2]  = acx_s1; dpb[2]  = apx_s1;
		dpa[3]  = acy_s1; dpb[3]  = apy_s1;
		dpa[4]  = abx_s1; dpb[4]  = bpx_s1;
		dpa[5]  = aby_s1; dpb[5]  = bpy_s1;
		dpa[6]  = acx_s1; dpb[6]  = bpx_s1;
		dpa[7]  = acy_s1; dpb[7]  = bpy_s1;
		dpa[8]  = abx_s1; dpb[8]  = cpx_s1;
		dpa[9]  = aby_s1; dpb[9]  = cpy_s1;
		dpa[10] = acx_s1; dpb[10] = cpx_s1;
		dpa[11] = acy_s1; dpb[11] = cpy_s1;
	end

	for (genvar g = 0; g < 12; g++) begin : g_dot
		cpot_mul #(.A_W(DIF_W), .B_W(DIF_W)) u_mul (
			.clk(clk), .en(en), .a(dpa[g]), .b(dpb[g]), .p(dpp[g])
		);
	end

	// stage 6: d1..d6 (index 0..5)
	logic signed [DOT_W-1:0] d_s6 [6];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				d_s6[i] <= DOT_W'(dpp[2*i]) + DOT_W'(dpp[2*i+1]);
			end
		end
	end

	// stage 7: edge terms, divisors and region flags
	logic signed [EDG_W-1:0] e43_c, e56_c;
	logic signed [TT_W-1:0]  t_c;
	logic signed [DOT_W-1:0] d_s7 [6];
	logic signed [TT_W-1:0]  t_s7;
	logic signed [EDG_W-1:0] den_ab_s7, den_ac_s7;
	logic signed [TT_W-1:0]  den_bc_s7;
	rgn_flags_t              rf_s7;

	always_comb begin
		e43_c = EDG_W'(d_s6[3]) - EDG_W'(d_s6[2]);
		e56_c = EDG_W'(d_s6[4]) - EDG_W'(d_s6[5]);
		t_c   = e43_c[EDG_W-1] ? -TT_W'(e43_c) : TT_W'(e43_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s7      <= d_s6;
			t_s7      <= t_c;
			den_ab_s7 <= EDG_W'(d_s6[0]) - EDG_W'(d_s6[2]);
			den_ac_s7 <= EDG_W'(d_s6[1]) - EDG_W'(d_s6[5]);
			den_bc_s7 <= t_c + TT_W'(e56_c);
			rf_s7.ca    <= (d_s6[0] <= 0) && (d_s6[1] <= 0);
			rf_s7.cb    <= (d_s6[2] >= 0) && (d_s6[3] <= 0);
			rf_s7.pab   <= (d_s6[0] >= 0) && (d_s6[2] <= 0);
			rf_s7.cc    <= (d_s6[5] >= 0) && (d_s6[4] <= d_s6[5]);
			rf_s7.pac   <= (d_s6[1] >= 0) && (d_s6[5] <= 0);
			rf_s7.e56ge <= d_s6[4] >= d_s6[5];
		end
	end

	logic [6*DIF_W-1:0]      geo7;
	logic signed [DIF_W-1:0] abx7, aby7, acx7, acy7, cbx7, cby7;

	cpot_dly #(.W(6*DIF_W), .N(6)) u_dly_geo (
		.clk(clk), .en(en),
		.d({abx_s1, aby_s1, acx_s1, acy_s1, cbx_s1, cby_s1}), .q(geo7)
	);
	assign {abx7, aby7, acx7, acy7, cbx7, cby7} = geo7;

	// second products, out at stage 11
	logic signed [DOT_W-1:0] vma [6];
	logic signed [DOT_W-1:0] vmb [6];
	logic signed [VP_W-1:0]  vmp [6];
	logic signed [TT_W-1:0]  nma [6];
	logic signed [DIF_W-1:0] nmb [6];
	logic signed [NP_W-1:0]  nmp [6];

	always_comb begin
		vma[0] = d_s7[0]; vmb[0] = d_s7[3];
		vma[1] = d_s7[2]; vmb[1] = d_s7[1];
		vma[2] = d_s7[4]; vmb[2] = d_s7[1];
		vma[3] = d_s7[0]; vmb[3] = d_s7[5];
		vma[4] = d_s7[2]; vmb[4] = d_s7[5];
		vma[5] = d_s7[4]; vmb[5] = d_s7[3];
		nma[0] = TT_W'(d_s7[0]); nmb[0] = abx7;
		nma[1] = TT_W'(d_s7[0]); nmb[1] = aby7;
		nma[2] = TT_W'(d_s7[1]); nmb[2] = acx7;
		nma[3] = TT_W'(d_s7[1]); nmb[3] = acy7;
		nma[4] = t_s7;           nmb[4] = cbx7;
		nma[5] = t_s7;           nmb[5] = cby7;
	end

	for (genvar g = 0; g < 6; g++) begin : g_lvl2
		cpot_mul #(.A_W(DOT_W), .B_W(DOT_W)) u_vmul (
			.clk(clk), .en(en), .a(vma[g]), .b(vmb[g]), .p(vmp[g])
		);
		cpot_mul #(.A_W(TT_W), .B_W(DIF_W)) u_nmul (
			.clk(clk), .en(en), .a(nma[g]), .b(nmb[g]), .p(nmp[g])
		);
	end

	// stage 12: vc, vb, va
	logic signed [VV_W-1:0] vc_s12, vb_s12, va_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			vc_s12 <= VV_W'(vmp[0]) - VV_W'(vmp[1]);
			vb_s12 <= VV_W'(vmp[2]) - VV_W'(vmp[3]);
			va_s12 <= VV_W'(vmp[4]) - VV_W'(vmp[5]);
		end
	end

	// stage 13: face divisor
	logic signed [DEN_W-1:0] dface_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			dface_s13 <= DEN_W'(va_s12) + DEN_W'(vb_s12) + DEN_W'(vc_s12);
		end
	end

	logic [4*DIF_W-1:0]      geo12;
	logic signed [DIF_W-1:0] abx12, aby12, acx12, acy12;

	cpot_dly #(.W(4*DIF_W), .N(5)) u_dly_geo12 (
		.clk(clk), .en(en), .d({abx7, aby7, acx7, acy7}), .q(geo12)
	);
	assign {abx12, aby12, acx12, acy12} = geo12;

	// face numerator products, out at stage 16
	logic signed [DIF_W-1:0] fma [4];
	logic signed [VV_W-1:0]  fmb [4];
	logic signed [FP_W-1:0]  fmp [4];

	always_comb begin
		fma[0] = abx12; fmb[0] = vb_s12;
		fma[1] = acx12; fmb[1] = vc_s12;
		fma[2] = aby12; fmb[2] = vb_s12;
		fma[3] = acy12; fmb[3] = vc_s12;
	end

	for (genvar g = 0; g < 4; g++) begin : g_face
		cpot_mul #(.A_W(DIF_W), .B_W(VV_W)) u_fmul (
			.clk(clk), .en(en), .a(fma[g]), .b(fmb[g]), .p(fmp[g])
		);
	end

	// stage 17: face numerators
	logic signed [NUM_W-1:0] fnx_s17, fny_s17;

	always_ff @(posedge clk) begin
		if (en) begin
			fnx_s17 <= NUM_W'(fmp[0]) + NUM_W'(fmp[1]);
			fny_s17 <= NUM_W'(fmp[2]) + NUM_W'(fmp[3]);
		end
	end

	// sideband aligned to stage 17
	logic [6*CRD_W-1:0]      crd17;
	logic signed [CRD_W-1:0] ax17, ay17, bx17, by17, cx17, cy17;
	rgn_flags_t              rf17;
	logic [2*EDG_W+TT_W-1:0] dens17;
	logic signed [EDG_W-1:0] den_ab17, den_ac17;
	logic signed [TT_W-1:0]  den_bc17;
	logic [6*NP_W-1:0]       np17;
	logic signed [NP_W-1:0]  n17 [6];
	logic [2:0]              vle_c, vle17;
	logic signed [DEN_W-1:0] dface17;

	cpot_dly #(.W(6*CRD_W), .N(16)) u_dly_crd (
		.clk(clk), .en(en),
		.d({ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1}), .q(crd17)
	);
	assign {ax17, ay17, bx17, by17, cx17, cy17} = crd17;

	cpot_dly #(.W($bits(rgn_flags_t)), .N(10)) u_dly_rf (
		.clk(clk), .en(en), .d(rf_s7), .q(rf17)
	);

	cpot_dly #(.W(2*EDG_W+TT_W), .N(10)) u_dly_den (
		.clk(clk), .en(en), .d({den_ab_s7, den_ac_s7, den_bc_s7}), .q(dens17)
	);
	assign {den_ab17, den_ac17, den_bc17} = dens17;

	cpot_dly #(.W(6*NP_W), .N(6)) u_dly_np (
		.clk(clk), .en(en),
		.d({nmp[0], nmp[1], nmp[2], nmp[3], nmp[4], nmp[5]}), .q(np17)
	);
	assign {n17[0], n17[1], n17[2], n17[3], n17[4], n17[5]} = np17;

	assign vle_c = {vc_s12 <= 0, vb_s12 <= 0, va_s12 <= 0};

	cpot_dly #(.W(3), .N(5)) u_dly_vle (
		.clk(clk), .en(en), .d(vle_c), .q(vle17)
	);

	cpot_dly #(.W(DEN_W), .N(4)) u_dly_dface (
		.clk(clk), .en(en), .d(dface_s13), .q(dface17)
	);

	// stage 18: region select
	logic                    sel_lerp, den_zero;
	logic signed [NUM_W-1:0] sel_nx, sel_ny;
	logic signed [DEN_W-1:0] sel_den;
	logic signed [CRD_W-1:0] sel_bx, sel_by, sel_dx, sel_dy;

	always_comb begin
		sel_lerp = 1'b1;
		sel_nx   = fnx_s17;
		sel_ny   = fny_s17;
		sel_den  = dface17;
		sel_bx   = ax17;
		sel_by   = ay17;
		sel_dx   = ax17;
		sel_dy   = ay17;
		if (rf17.ca) begin
			sel_lerp = 1'b0;
		end else if (rf17.cb) begin
			sel_lerp = 1'b0;
			sel_dx   = bx17;
			sel_dy   = by17;
		end else if (vle17[2] && rf17.pab) begin
			sel_nx  = NUM_W'(n17[0]);
			sel_ny  = NUM_W'(n17[1]);
			sel_den = DEN_W'(den_ab17);
		end else if (rf17.cc) begin
			sel_lerp = 1'b0;
			sel_dx   = cx17;
			sel_dy   = cy17;
		end else if (vle17[1] && rf17.pac) begin
			sel_nx  = NUM_W'(n17[2]);
			sel_ny  = NUM_W'(n17[3]);
			sel_den = DEN_W'(den_ac17);
		end else if (vle17[0] && rf17.e56ge) begin
			sel_nx  = NUM_W'(n17[4]);
			sel_ny  = NUM_W'(n17[5]);
			sel_den = DEN_W'(den_bc17);
			sel_bx  = bx17;
			sel_by  = by17;
		end
		den_zero = sel_lerp && (sel_den == 0);
	end

	logic signed [NUM_W-1:0] nx_s18, ny_s18;
	logic signed [DEN_W-1:0] den_s18;
	logic signed [CRD_W-1:0] bx_s18, by_s18, dx_s18, dy_s18;
	logic                    udiv_s18, deg_s18;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s18   <= sel_nx;
			ny_s18   <= sel_ny;
			den_s18  <= sel_den;
			bx_s18   <= sel_bx;
			by_s18   <= sel_by;
			dx_s18   <= sel_dx;
			dy_s18   <= sel_dy;
			udiv_s18 <= sel_lerp && !den_zero;
			deg_s18  <= den_zero;
		end
	end

	// dividers, out at stage 54
	logic [QB-1:0] qx, qy;
	div_flags_t    fx, fy;

	cpot_div u_div_x (
		.clk(clk), .en(en), .num(nx_s18), .den(den_s18), .quo(qx), .flg(fx)
	);
	cpot_div u_div_y (
		.clk(clk), .en(en), .num(ny_s18), .den(den_s18), .quo(qy), .flg(fy)
	);

	logic [4*CRD_W+1:0]      sb54;
	logic signed [CRD_W-1:0] bx54, by54, dx54, dy54;
	logic                    udiv54, deg54;

	cpot_dly #(.W(4*CRD_W+2), .N(DIV_LAT)) u_dly_sb (
		.clk(clk), .en(en),
		.d({bx_s18, by_s18, dx_s18, dy_s18, udiv_s18, deg_s18}), .q(sb54)
	);
	assign {bx54, by54, dx54, dy54, udiv54, deg54} = sb54;

	function automatic logic [CRD_W-1:0] sat_add(
		input logic signed [CRD_W-1:0] base,
		input logic [QB-1:0]           q,
		input div_flags_t              f
	);
		logic signed [SUM_W-1:0] qs;
		logic signed [SUM_W-1:0] sum;
		logic [CRD_W-1:0]        r;
		qs = SUM_W'(q);
		if (f.negq) begin
			qs = -qs;
		end
		sum = SUM_W'(base) + qs;
		if (f.ovf) begin
			r = f.negq ? CRD_MIN : CRD_MAX;
		end else if (sum > SUM_W'(CRD_MAX)) begin
			r = CRD_MAX;
		end else if (sum < SUM_W'(CRD_MIN)) begin
			r = CRD_MIN;
		end else begin
			r = sum[CRD_W-1:0];
		end
		return r;
	endfunction

	// stage 55: output register
	logic signed [CRD_W-1:0] rx_s55, ry_s55;
	logic                    deg_s55;

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s55  <= udiv54 ? sat_add(bx54, qx, fx) : dx54;
			ry_s55  <= udiv54 ? sat_add(by54, qy, fy) : dy54;
			deg_s55 <= deg54;
		end
	end

	assign closest_x  = rx_s55;
	assign closest_y  = ry_s55;
	assign degenerate = deg_s55;

endmodule
`default_nettype wire

/* hdl/cpot_dly.sv */
// Enabled delay line for sideband data.
`default_nettype none
module cpot_dly #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign q = sr_q[N-1];

endmodule
`default_nettype wire

/* hdl/cpot_mul.sv */
// Pipelined signed multiplier built from 32x32 partial products, four stages.
`default_nettype none
module cpot_mul #(
	parameter int A_W = 33,
	parameter int B_W = 33
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [A_W-1:0]  a,
	input  wire logic signed [B_W-1:0]  b,
	output logic signed [A_W+B_W-1:0]   p
);

	localparam int NA = (A_W + 31) / 32;
	localparam int NB = (B_W + 31) / 32;
	localparam int AP = NA * 32;
	localparam int BP = NB * 32;
	localparam int RW = BP + 32;
	localparam int TW = AP + BP;
	localparam int PW = A_W + B_W;

	logic [A_W-1:0] am_c;
	logic [B_W-1:0] bm_c;
	logic [AP-1:0]  am_s1;
	logic [BP-1:0]  bm_s1;
	logic           neg_s1, neg_s2, neg_s3;
	logic [63:0]    pp_s2 [NA][NB];
	logic [RW-1:0]  row_c [NA];
	logic [RW-1:0]  row_s3 [NA];
	logic [PW-1:0]  p_c;
	logic signed [PW-1:0] p_s4;

	always_comb begin
		am_c = a[A_W-1] ? A_W'(-a) : A_W'(a);
		bm_c = b[B_W-1] ? B_W'(-b) : B_W'(b);
	end

	always_comb begin
		logic [RW-1:0] acc;
		for (int i = 0; i < NA; i++) begin
			acc = '0;
			for (int j = 0; j < NB; j++) begin
				acc = acc + (RW'(pp_s2[i][j]) << (32 * j));
			end
			row_c[i] = acc;
		end
	end

	always_comb begin
		logic [TW-1:0] tot;
		logic [PW-1:0] mag;
		tot = '0;
		for (int i = 0; i < NA; i++) begin
			tot = tot + (TW'(row_s3[i]) << (32 * i));
		end
		mag = tot[PW-1:0];
		p_c = neg_s3 ? PW'(-mag) : mag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1  <= AP'(am_c);
			bm_s1  <= BP'(bm_c);
			neg_s1 <= a[A_W-1] ^ b[B_W-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= 64'(am_s1[32*i +: 32]) * 64'(bm_s1[32*j +: 32]);
				end
			end
			neg_s2 <= neg_s1;
			row_s3 <= row_c;
			neg_s3 <= neg_s2;
			p_s4   <= p_c;
		end
	end

	assign p = p_s4;

endmodule
`default_nettype wire

/* hdl/cpot_div.sv */
// Pipelined restoring divider: magnitude quotient, one bit per stage.
`default_nettype none
module cpot_div
	import cpot_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [NUM_W-1:0]  num,
	input  wire logic signed [DEN_W-1:0]  den,
	output logic [QB-1:0]                 quo,
	output div_flags_t                    flg
);

	localparam int RW = DEN_W + QB + 1;

	logic [NUM_W-1:0] nm_s1;
	logic [DEN_W-1:0] dm_s1;
	logic             negq_s1;

	logic [RW-1:0]    rem_s [QB+1];
	logic [QB-1:0]    quo_s [QB+1];
	logic [DEN_W-1:0] dm_s  [QB+1];
	div_flags_t       flg_s [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s1   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			dm_s1   <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
			negq_s1 <= num[NUM_W-1] ^ den[DEN_W-1];
			rem_s[0]      <= RW'(nm_s1);
			quo_s[0]      <= '0;
			dm_s[0]       <= dm_s1;
			flg_s[0].ovf  <= RW'(nm_s1) >= (RW'(dm_s1) << QB);
			flg_s[0].negq <= negq_s1;
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_stage
		localparam int K = QB - 1 - i;
		logic [RW:0] dif;
		assign dif = {1'b0, rem_s[i]} - {1'b0, RW'(dm_s[i]) << K};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= dif[RW] ? rem_s[i] : dif[RW-1:0];
				quo_s[i+1] <= quo_s[i] | (QB'(!dif[RW]) << K);
				dm_s[i+1]  <= dm_s[i];
				flg_s[i+1] <= flg_s[i];
			end
		end
	end

	assign quo = quo_s[QB];
	assign flg = flg_s[QB];

endmodule
`default_nettype wire

/* sim/cpot_checker.sv */
// Checker for the closest-point-on-triangle unit: predicts and compares results.
`timescale 1ns / 1ps
`default_nettype none
module cpot_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] corner_a_x,
	input  wire logic signed [31:0] corner_a_y,
	input  wire logic signed [31:0] corner_b_x,
	input  wire logic signed [31:0] corner_b_y,
	input  wire logic signed [31:0] corner_c_x,
	input  wire logic signed [31:0] corner_c_y,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [31:0] closest_x,
	input  wire logic signed [31:0] closest_y,
	input  wire logic               degenerate,
	output int                      fail_count,
	output int                      pending,
	output int                      done_count
);

	typedef logic signed [191:0] wide_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               deg;
	} nearest_t;

	nearest_t nearest_q[$];

	function automatic logic signed [31:0] lerp_sat(input wide_t base, input wide_t num,
			input wide_t den);
		wide_t q;
		wide_t r;
		q = num / den;
		r = base + q;
		if (r > wide_t'(2147483647))
			r = wide_t'(2147483647);
		if (r < wide_t'(-64'sd2147483648))
			r = wide_t'(-64'sd2147483648);
		return r[31:0];
	endfunction

	function automatic nearest_t nearest_point(input wide_t px, input wide_t py,
			input wide_t ax, input wide_t ay, input wide_t bx, input wide_t by,
			input wide_t cx, input wide_t cy);
		wide_t abx, aby, acx, acy, d1, d2, d3, d4, d5, d6;
		wide_t vc, vb, va, den, t, e56;
		nearest_t r;
		abx = bx - ax;
		aby = by - ay;
		acx = cx - ax;
		acy = cy - ay;
		d1 = abx * (px - ax) + aby * (py - ay);
		d2 = acx * (px - ax) + acy * (py - ay);
		d3 = abx * (px - bx) + aby * (py - by);
		d4 = acx * (px - bx) + acy * (py - by);
		d5 = abx * (px - cx) + aby * (py - cy);
		d6 = acx * (px - cx) + acy * (py - cy);
		vc = d1 * d4 - d3 * d2;
		vb = d5 * d2 - d1 * d6;
		va = d3 * d6 - d5 * d4;
		r.x = ax[31:0];
		r.y = ay[31:0];
		r.deg = 1'b0;
		if (d1 <= 0 && d2 <= 0)
			return r;
		if (d3 >= 0 && d4 <= 0) begin
			r.x = bx[31:0];
			r.y = by[31:0];
			return r;
		end
		if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
			den = d1 - d3;
			if (den == 0) begin
				r.deg = 1'b1;
				return r;
			end
			r.x = lerp_sat(ax, d1 * abx, den);
			r.y = lerp_sat(ay, d1 * aby, den);
			return r;
		end
		if (d6 >= 0 && d5 <= d6) begin
			r.x = cx[31:0];
			r.y = cy[31:0];
			return r;
		end
		if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
			den = d2 - d6;
			if (den == 0) begin
				r.deg = 1'b1;
				return r;
			end
			r.x = lerp_sat(ax, d2 * acx, den);
			r.y = lerp_sat(ay, d2 * acy, den);
			return r;
		end
		e56 = d5 - d6;
		if (va <= 0 && e56 >= 0) begin
			t = d4 - d3;
			if (t < 0)
				t = -t;
			den = t + e56;
			if (den == 0) begin
				r.deg = 1'b1;
				return r;
			end
			r.x = lerp_sat(bx, t * (cx - bx), den);
			r.y = lerp_sat(by, t * (cy - by), den);
			return r;
		end
		den = va + vb + vc;
		if (den == 0) begin
			r.deg = 1'b1;
			return r;
		end
		r.x = lerp_sat(ax, abx * vb + acx * vc, den);
		r.y = lerp_sat(ay, aby * vb + acy * vc, den);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		nearest_t want;
		if (!arst_n) begin
			fail_count <= 0;
			done_count <= 0;
			pending <= 0;
			nearest_q.delete();
		end else begin
			if (in_valid && in_ready)
				nearest_q.push_back(nearest_point(point_x, point_y, corner_a_x, corner_a_y,
					corner_b_x, corner_b_y, corner_c_x, corner_c_y));
			if (out_valid && out_ready) begin
				done_count <= done_count + 1;
				if (nearest_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result x=%0d y=%0d deg=%0b",
							closest_x, closest_y, degenerate);
				end else begin
					want = nearest_q.pop_front();
					if (want.x !== closest_x || want.y !== closest_y
							|| want.deg !== degenerate) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: exp x=%0d y=%0d deg=%0b got x=%0d y=%0d deg=%0b",
								want.x, want.y, want.deg, closest_x, closest_y, degenerate);
					end
				end
			end
			pending <= nearest_q.size();
		end
	end

endmodule
`default_nettype wire

/* sim/tb_closest_point_on_triangle_unit.sv */
// Testbench top: drives requests into the triangle unit and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_closest_point_on_triangle_unit;

	localparam int RANDOM_REQS = 1880;
	localparam int STALL_LIMIT = 5000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] point_x, point_y;
	logic signed [31:0] corner_a_x, corner_a_y, corner_b_x, corner_b_y;
	logic signed [31:0] corner_c_x, corner_c_y;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] closest_x, closest_y;
	logic               degenerate;
	int                 fail_count, pending, done_count;
	int                 send_idle_pct, recv_idle_pct;
	int                 hold_cycles;
	int                 idle_cycles;
	int                 sent;

	closest_point_on_triangle_unit i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y),
		.corner_a_x(corner_a_x), .corner_a_y(corner_a_y),
		.corner_b_x(corner_b_x), .corner_b_y(corner_b_y),
		.corner_c_x(corner_c_x), .corner_c_y(corner_c_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.closest_x(closest_x), .closest_y(closest_y), .degenerate(degenerate)
	);

	cpot_checker i_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y),
		.corner_a_x(corner_a_x), .corner_a_y(corner_a_y),
		.corner_b_x(corner_b_x), .corner_b_y(corner_b_y),
		.corner_c_x(corner_c_x), .corner_c_y(corner_c_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.closest_x(closest_x), .closest_y(closest_y), .degenerate(degenerate),
		.fail_count(fail_count), .pending(pending), .done_count(done_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no progress");
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_coord(input int spread);
		case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $urandom;
			3: return 0;
			default: return $signed($urandom_range(2 * spread)) - spread;
		endcase
	endfunction

	// in_valid stays high after acceptance; the caller drops it when a batch ends
	task automatic send_request(input logic signed [31:0] px, py, ax, ay, bx, by, cx, cy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		corner_a_x <= ax;
		corner_a_y <= ay;
		corner_b_x <= bx;
		corner_b_y <= by;
		corner_c_x <= cx;
		corner_c_y <= cy;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_random;
		int s;
		logic signed [31:0] ax, ay;
		s = ($urandom_range(3) == 0) ? 32'h4000_0000 : 32'h0040_0000;
		ax = rand_coord(s);
		ay = rand_coord(s);
		case ($urandom_range(7))
			0: send_request(rand_coord(s), rand_coord(s), ax, ay, ax, ay, ax, ay);
			1: send_request(rand_coord(s), rand_coord(s), ax, ay,
				rand_coord(s), rand_coord(s), ax, ay);
			2: send_request(ax + ($urandom_range(2000) - 1000), ay, ax, ay,
				ax + 32'sh0001_0000, ay, ax, ay + 32'sh0001_0000);
			default: send_request(rand_coord(s), rand_coord(s), ax, ay,
				rand_coord(s), rand_coord(s), rand_coord(s), rand_coord(s));
		endcase
	endtask

	localparam logic signed [31:0] ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] MAXC = 32'sh7fff_ffff;
	localparam logic signed [31:0] MINC = 32'sh8000_0000;

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		hold_cycles = 0;
		idle_cycles = 0;
		sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		{point_x, point_y, corner_a_x, corner_a_y} = '0;
		{corner_b_x, corner_b_y, corner_c_x, corner_c_y} = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: each region, degenerate triangles, extreme coordinates
		send_request(-ONE, -ONE, 0, 0, 4 * ONE, 0, 0, 4 * ONE);
		send_request(6 * ONE, -ONE, 0, 0, 4 * ONE, 0, 0, 4 * ONE);
		send_request(2 * ONE, -3 * ONE, 0, 0, 4 * ONE, 0, 0, 4 * ONE);
		send_request(-ONE, 6 * ONE, 0, 0, 4 * ONE, 0, 0, 4 * ONE);
		send_request(-3 * ONE, 2 * ONE, 0, 0, 4 * ONE, 0, 0, 4 * ONE);
		send_request(3 * ONE, 3 * ONE, 0, 0, 4 * ONE, 0, 0, 4 * ONE);
		send_request(ONE, ONE, 0, 0, 4 * ONE, 0, 0, 4 * ONE);
		send_request(ONE, ONE, 0, 0, 4 * ONE, 0, 4 * ONE, 0);
		send_request(ONE, 2 * ONE, 0, 0, 0, 0, 0, 0);
		send_request(ONE, 2 * ONE, 0, 0, 0, 0, 3 * ONE, ONE);
		send_request(ONE, 2 * ONE, 0, 0, 2 * ONE, 2 * ONE, 4 * ONE, 4 * ONE);
		send_request(2 * ONE, ONE, 0, 0, 4 * ONE, 0, 8 * ONE, 0);
		send_request(MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC);
		send_request(MINC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC);
		send_request(0, 0, MINC, MINC, MAXC, MINC, MINC, MAXC);
		send_request(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC);
		send_request(-1, -1, -1, -1, -1, -1, -1, -1);
		send_request(MAXC, MAXC, 0, 0, MINC, 0, 0, MINC);
		send_request($urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);

		// receiver holds off while requests keep coming, then drain fully
		hold_cycles = 200;
		for (i = 0; i < 80; i++)
			send_random();
		in_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 82;
		for (i = 0; i < RANDOM_REQS / 3; i++)
			send_random();
		send_idle_pct = 82;
		recv_idle_pct = 31;
		for (i = 0; i < RANDOM_REQS / 3; i++)
			send_random();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (i = 0; i < RANDOM_REQS / 3; i++)
			send_random();
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (70) @(negedge clk);
		$display("sent %0d requests, checked %0d results", sent, done_count);
		$display("covered vertex, edge, face and degenerate cases under stalls");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
